@@ sv/dcl_pkg.sv @@
package dcl_pkg;

    localparam int unsigned MAX_HEX_CHARS    = 128;
    localparam int unsigned MAX_NUMBER_CHARS = 20;
    localparam int unsigned PATH_LENGTH_MAX  = 65535;
    localparam int unsigned HDR_LEN          = 17;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_HDR_BAD     = 3'd1,
        ST_FEW_FIELDS  = 3'd2,
        ST_BAD_HEX     = 3'd3,
        ST_BAD_SIZE    = 3'd4,
        ST_BAD_MTIME   = 3'd5,
        ST_EMPTY_PATH  = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_kind              result_kind;
        t_status            line_status;
        logic signed [63:0] size_value;
        logic signed [63:0] mtime_value;
        logic [7:0]         hex_length;
        logic [15:0]        path_length;
        logic [31:0]        line_number;
        logic [31:0]        records_accepted;
    } t_out_item;

    function automatic logic [7:0] hdr_byte(input logic [4:0] pos);
        logic [7:0] b;
        case (pos)
            5'd0:    b = 8'h23;
            5'd1:    b = 8'h73;
            5'd2:    b = 8'h78;
            5'd3:    b = 8'h63;
            5'd4:    b = 8'h6C;
            5'd5:    b = 8'h2D;
            5'd6:    b = 8'h68;
            5'd7:    b = 8'h61;
            5'd8:    b = 8'h73;
            5'd9:    b = 8'h68;
            5'd10:   b = 8'h63;
            5'd11:   b = 8'h61;
            5'd12:   b = 8'h63;
            5'd13:   b = 8'h68;
            5'd14:   b = 8'h65;
            5'd15:   b = 8'h20;
            5'd16:   b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

endpackage

@@ sv/dcl_in_reg.sv @@
module dcl_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dcl_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output dcl_pkg::t_in_item o_item
);

    logic              r_valid;
    dcl_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ sv/dcl_parse_core.sv @@
module dcl_parse_core #(
    parameter int unsigned MAX_HEX_CHARS    = dcl_pkg::MAX_HEX_CHARS,
    parameter int unsigned MAX_NUMBER_CHARS = dcl_pkg::MAX_NUMBER_CHARS,
    parameter int unsigned PATH_LENGTH_MAX  = dcl_pkg::PATH_LENGTH_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  dcl_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    output dcl_pkg::t_out_item o_res_item
);

    localparam logic [4:0]  HdrLen    = 5'(dcl_pkg::HDR_LEN);
    localparam logic [7:0]  MaxHex    = 8'(MAX_HEX_CHARS);
    localparam logic [7:0]  MaxNum    = 8'(MAX_NUMBER_CHARS);
    localparam logic [15:0] PathMax   = 16'(PATH_LENGTH_MAX);
    localparam logic [63:0] MinMag    = 64'h8000_0000_0000_0000;

    logic        r_hdr_done, n_hdr_done;
    logic        r_hdr_good, n_hdr_good;
    logic [4:0]  r_hdr_pos, n_hdr_pos;
    logic [1:0]  r_fnum, n_fnum;
    logic [7:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic        r_minus, n_minus;
    logic [2:0]  r_ferr, n_ferr;
    logic [63:0] r_size, n_size;
    logic [7:0]  r_hexlen, n_hexlen;
    logic [15:0] r_path, n_path;
    logic        r_pcr, n_pcr;
    logic        r_lhb, n_lhb;
    logic [31:0] r_line, n_line;
    logic [31:0] r_rec, n_rec;

    always_comb begin
        logic [7:0]  c;
        logic [2:0]  code;
        logic [2:0]  st;
        logic [67:0] prod;
        logic [63:0] val;
        logic        hg;
        logic        bad;

        c    = i_item.data_byte;
        code = dcl_pkg::ST_OK;
        st   = dcl_pkg::ST_OK;
        prod = '0;
        val  = '0;
        hg   = r_hdr_good;
        bad  = 1'b0;

        n_hdr_done = r_hdr_done;
        n_hdr_good = r_hdr_good;
        n_hdr_pos  = r_hdr_pos;
        n_fnum     = r_fnum;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_minus    = r_minus;
        n_ferr     = r_ferr;
        n_size     = r_size;
        n_hexlen   = r_hexlen;
        n_path     = r_path;
        n_pcr      = r_pcr;
        n_lhb      = r_lhb;
        n_line     = r_line;
        n_rec      = r_rec;

        o_res_valid = 1'b0;
        o_res_item  = '0;

        if (i_item.end_of_stream) begin
            o_res_valid                 = 1'b1;
            o_res_item.result_kind      = dcl_pkg::KIND_END;
            o_res_item.line_number      = r_line;
            o_res_item.records_accepted = r_rec;
            n_hdr_done = 1'b0;
            n_hdr_good = 1'b1;
            n_hdr_pos  = '0;
            n_line     = '0;
            n_rec      = '0;
            n_fnum     = '0;
            n_cnt      = '0;
            n_acc      = '0;
            n_minus    = 1'b0;
            n_ferr     = '0;
            n_size     = '0;
            n_hexlen   = '0;
            n_path     = '0;
            n_pcr      = 1'b0;
            n_lhb      = 1'b0;
        end else if (!r_hdr_done) begin
            if (c == dcl_pkg::CH_LF) begin
                hg = r_hdr_good && (r_hdr_pos == HdrLen);
                n_hdr_done = 1'b1;
                n_hdr_good = hg;
                n_hdr_pos  = '0;
                n_pcr      = 1'b0;
                n_line     = 32'd1;
                o_res_valid            = 1'b1;
                o_res_item.result_kind = dcl_pkg::KIND_HEADER;
                o_res_item.line_status = hg ? dcl_pkg::ST_OK : dcl_pkg::ST_HDR_BAD;
            end else begin
                if (r_pcr) begin
                    n_pcr = 1'b0;
                    hg    = 1'b0;
                end
                if (hg) begin
                    priority if (r_hdr_pos < HdrLen && c == dcl_pkg::hdr_byte(r_hdr_pos)) begin
                        n_hdr_pos = r_hdr_pos + 5'd1;
                    end else if (r_hdr_pos == HdrLen && c == dcl_pkg::CH_CR) begin
                        n_pcr = 1'b1;
                    end else begin
                        hg = 1'b0;
                    end
                end
                n_hdr_good = hg;
            end
        end else if (!r_hdr_good) begin
            n_line = r_line;
        end else if (c == dcl_pkg::CH_LF) begin
            n_line = r_line + 32'd1;
            if (r_lhb) begin
                priority if (r_fnum != 2'd3) begin
                    st = dcl_pkg::ST_FEW_FIELDS;
                end else if (r_ferr != dcl_pkg::ST_OK) begin
                    st = r_ferr;
                end else if (r_path == 16'd0) begin
                    st = dcl_pkg::ST_EMPTY_PATH;
                end else begin
                    st = dcl_pkg::ST_OK;
                end
                o_res_valid            = 1'b1;
                o_res_item.result_kind = dcl_pkg::KIND_RECORD;
                o_res_item.line_status = dcl_pkg::t_status'(st);
                if (st == dcl_pkg::ST_OK) begin
                    o_res_item.size_value  = r_size;
                    o_res_item.mtime_value = r_acc;
                    o_res_item.hex_length  = r_hexlen;
                    n_rec = r_rec + 32'd1;
                end
                o_res_item.path_length = (r_fnum == 2'd3) ? r_path : 16'd0;
                o_res_item.line_number = r_line;
            end
            n_fnum   = '0;
            n_cnt    = '0;
            n_acc    = '0;
            n_minus  = 1'b0;
            n_ferr   = '0;
            n_size   = '0;
            n_hexlen = '0;
            n_path   = '0;
            n_pcr    = 1'b0;
            n_lhb    = 1'b0;
        end else begin
            code = (r_fnum == 2'd0) ? dcl_pkg::ST_BAD_HEX :
                   (r_fnum == 2'd1) ? dcl_pkg::ST_BAD_SIZE : dcl_pkg::ST_BAD_MTIME;
            // held-back CR is never a TAB and never valid in hex or number fields
            if (r_pcr) begin
                n_pcr = 1'b0;
                n_lhb = 1'b1;
                if (r_fnum == 2'd3) begin
                    if (n_path < PathMax) n_path = n_path + 16'd1;
                end else begin
                    if (n_ferr == dcl_pkg::ST_OK) n_ferr = code;
                    if (n_cnt != 8'hFF) n_cnt = n_cnt + 8'd1;
                end
            end
            if (c == dcl_pkg::CH_CR) begin
                n_pcr = 1'b1;
            end else begin
                n_lhb = 1'b1;
                unique case (r_fnum)
                    2'd0: begin
                        if (c == dcl_pkg::CH_TAB) begin
                            if (n_cnt == 8'd0 && n_ferr == dcl_pkg::ST_OK) n_ferr = code;
                            n_hexlen = n_cnt;
                            n_fnum   = 2'd1;
                            n_cnt    = '0;
                            n_acc    = '0;
                            n_minus  = 1'b0;
                        end else begin
                            if ((!dcl_pkg::is_hex(c) || n_cnt >= MaxHex) &&
                                n_ferr == dcl_pkg::ST_OK) n_ferr = code;
                            if (n_cnt != 8'hFF) n_cnt = n_cnt + 8'd1;
                        end
                    end
                    2'd1, 2'd2: begin
                        if (c == dcl_pkg::CH_TAB) begin
                            bad = (n_cnt == 8'd0) || (r_minus && n_cnt == 8'd1);
                            if (r_minus) begin
                                bad = bad || (r_acc > MinMag);
                                val = 64'd0 - r_acc;
                            end else begin
                                bad = bad || r_acc[63];
                                val = r_acc;
                            end
                            if (bad && n_ferr == dcl_pkg::ST_OK) n_ferr = code;
                            if (r_fnum == 2'd1) begin
                                n_size = val;
                                n_acc  = '0;
                            end else begin
                                n_acc  = val;
                            end
                            n_fnum  = r_fnum + 2'd1;
                            n_cnt   = '0;
                            n_minus = 1'b0;
                        end else begin
                            prod = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} +
                                   {60'd0, c - 8'h30};
                            priority if (n_cnt >= MaxNum) begin
                                bad = 1'b1;
                            end else if (n_cnt == 8'd0 && c == dcl_pkg::CH_MINUS) begin
                                n_minus = 1'b1;
                            end else if (c >= 8'h30 && c <= 8'h39) begin
                                if (prod[67:64] != 4'd0) bad = 1'b1;
                                else n_acc = prod[63:0];
                            end else begin
                                bad = 1'b1;
                            end
                            if (bad && n_ferr == dcl_pkg::ST_OK) n_ferr = code;
                            if (n_cnt != 8'hFF) n_cnt = n_cnt + 8'd1;
                        end
                    end
                    default: begin
                        if (n_path < PathMax) n_path = n_path + 16'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_done <= 1'b0;
            r_hdr_good <= 1'b1;
            r_hdr_pos  <= '0;
            r_fnum     <= '0;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_minus    <= 1'b0;
            r_ferr     <= '0;
            r_size     <= '0;
            r_hexlen   <= '0;
            r_path     <= '0;
            r_pcr      <= 1'b0;
            r_lhb      <= 1'b0;
            r_line     <= '0;
            r_rec      <= '0;
        end else if (i_fire) begin
            r_hdr_done <= n_hdr_done;
            r_hdr_good <= n_hdr_good;
            r_hdr_pos  <= n_hdr_pos;
            r_fnum     <= n_fnum;
            r_cnt      <= n_cnt;
            r_acc      <= n_acc;
            r_minus    <= n_minus;
            r_ferr     <= n_ferr;
            r_size     <= n_size;
            r_hexlen   <= n_hexlen;
            r_path     <= n_path;
            r_pcr      <= n_pcr;
            r_lhb      <= n_lhb;
            r_line     <= n_line;
            r_rec      <= n_rec;
        end
    end

endmodule

@@ sv/digest_cache_line_parser.sv @@
// Byte-stream parser for a digest cache text file. One byte (or one end-of-stream marker) is
// taken per cycle, back to back, except while the input stalls. A transfer is held in the
// input register while the per-byte state update with its multiply-by-ten accumulate forms
// the result, which is registered into the result register and offered from there. The
// input stalls only while the input register is full and a result in the result register
// is not taken. The first line is checked against the fixed header and gives a header
// verdict; each later non-empty line gives one record result with its status, sizes and
// counts; end_of_stream gives the end result with the line and record totals and returns
// the parser to expect a new header. Bytes after a mismatched header give no results until
// end_of_stream.
module digest_cache_line_parser #(
    parameter int unsigned MAX_HEX_CHARS    = dcl_pkg::MAX_HEX_CHARS,
    parameter int unsigned MAX_NUMBER_CHARS = dcl_pkg::MAX_NUMBER_CHARS,
    parameter int unsigned PATH_LENGTH_MAX  = dcl_pkg::PATH_LENGTH_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dcl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dcl_pkg::t_out_item o_out_item
);

    logic               w_q_valid;
    logic               w_take;
    logic               w_res_valid;
    dcl_pkg::t_in_item  w_q_item;
    dcl_pkg::t_out_item w_res_item;
    logic               r_out_valid;
    dcl_pkg::t_out_item r_out_item;

    assign w_take = w_q_valid && (!r_out_valid || i_out_ready);

    dcl_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_q_valid),
        .i_take  (w_take),
        .o_item  (w_q_item)
    );

    dcl_parse_core #(
        .MAX_HEX_CHARS    (MAX_HEX_CHARS),
        .MAX_NUMBER_CHARS (MAX_NUMBER_CHARS),
        .PATH_LENGTH_MAX  (PATH_LENGTH_MAX)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_take),
        .i_item      (w_q_item),
        .o_res_valid (w_res_valid),
        .o_res_item  (w_res_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_out_item <= w_res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_q_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    a_rec_only_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind != dcl_pkg::KIND_END)
            |-> (o_out_item.records_accepted == 32'd0))
        else $error("record total outside end result");

    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.line_status != dcl_pkg::ST_OK)
            |-> (o_out_item.size_value == 64'sd0 && o_out_item.mtime_value == 64'sd0 &&
                 o_out_item.hex_length == 8'd0))
        else $error("values on failed line");

    a_hdr_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == dcl_pkg::KIND_HEADER)
            |-> (o_out_item.line_number == 32'd0 &&
                 (o_out_item.line_status == dcl_pkg::ST_OK ||
                  o_out_item.line_status == dcl_pkg::ST_HDR_BAD)))
        else $error("malformed header verdict");

endmodule
